### design/sfd_pkg.sv
// sfd_pkg: shared types and constants of the serial frame deframer
// no dependencies; compiled first

package sfd_pkg;

  // frame markers and positions inside the frame store
  localparam logic [7:0] MARK_HEAD = 8'hEF;
  localparam logic [7:0] MARK_TAIL = 8'hFF;
  localparam int ADDR1_POS = 2;
  localparam int ADDR2_POS = 3;
  localparam int LEN_POS = 5;
  localparam int TYPE_POS = 6;
  localparam int PAYLOAD_POS = 7;

  // result limits
  localparam int MAX_RESULTS = 56;
  localparam int PLEN_W = 6;

  // default store depth per bank
  localparam int STORE_DEPTH_DEFAULT = 64;

  // descriptor of a completed frame, front to back
  typedef struct packed {
    logic              bank;
    logic [7:0]        addr_first;
    logic [7:0]        addr_second;
    logic [7:0]        frame_type;
    logic [PLEN_W-1:0] plen;
  } sfd_desc_t;

  // bank handed back by the back part
  typedef struct packed {
    logic valid;
    logic bank;
  } sfd_release_t;

  // store write control (index travels separately)
  typedef struct packed {
    logic       en;
    logic       bank;
    logic [7:0] data;
  } sfd_wr_t;

  // store read control (index travels separately)
  typedef struct packed {
    logic en;
    logic bank;
  } sfd_rd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SHOW
  } sfd_back_state_e;

endpackage

### design/sfd_if.sv
// sfd_byte_if and sfd_result_if: valid/ready channels of the deframer
// no dependencies

interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] address_first;
  logic [7:0] address_second;
  logic [7:0] frame_type;
  logic [5:0] payload_length;
  logic       payload_present;
  logic [7:0] payload_value;
  logic       final_of_frame;

  modport source (
    output valid, output address_first, output address_second, output frame_type,
    output payload_length, output payload_present, output payload_value,
    output final_of_frame, input ready
  );
  modport sink (
    input valid, input address_first, input address_second, input frame_type,
    input payload_length, input payload_present, input payload_value,
    input final_of_frame, output ready
  );
endinterface

### design/serial_frame_deframer_core.sv
// serial_frame_deframer_core: top level of the serial frame deframer
// depends on sfd_pkg, sfd_if, sfd_store, sfd_queue, sfd_front, sfd_back
//
// Bytes enter on rx_i and are taken one per cycle while the store bank being
// filled is free. Two 0xEF bytes in a row restart a frame; a 0xFF at a
// position one less than the length byte (frame byte 5) ends it. The finished
// frame's bank is handed to the back part through a two-entry queue and the
// front goes on filling the other bank. The back part gives one result per
// payload byte (header-only frames give one result); each payload result is
// read through the store's registered read port in BK_FETCH and presented on
// res_o in BK_SHOW, and each frame's descriptor is first taken from the queue
// in BK_IDLE. The input stalls only while both banks hold frames that are still
// being emitted. There is no clearing pass after reset.

module serial_frame_deframer_core #(
  parameter int STORE_DEPTH = sfd_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfd_byte_if.sink     rx_i,
  sfd_result_if.source res_o
);
  import sfd_pkg::*;

  localparam int IW = $clog2(STORE_DEPTH);

  logic         push;
  sfd_desc_t    push_desc;
  logic         q_full;
  logic         q_empty;
  logic         pop;
  sfd_desc_t    q_head;
  sfd_wr_t      wr;
  logic [IW-1:0] wr_idx;
  sfd_rd_t      rd;
  logic [IW-1:0] rd_idx;
  logic [7:0]   rd_data;
  sfd_release_t rel;

  // byte intake and frame assembly
  sfd_front #(.STORE_DEPTH(STORE_DEPTH), .IW(IW)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx       (rx_i),
    .push_o   (push),
    .desc_o   (push_desc),
    .q_full_i (q_full),
    .wr_o     (wr),
    .wr_idx_o (wr_idx),
    .rel_i    (rel)
  );

  // completed frame descriptors
  sfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // two-bank frame store
  sfd_store #(.STORE_DEPTH(STORE_DEPTH), .IW(IW)) u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .wr_idx_i  (wr_idx),
    .rd_i      (rd),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data)
  );

  // result emission
  sfd_back #(.STORE_DEPTH(STORE_DEPTH), .IW(IW)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .pop_o     (pop),
    .rd_o      (rd),
    .rd_idx_o  (rd_idx),
    .rd_data_i (rd_data),
    .rel_o     (rel),
    .res       (res_o)
  );

endmodule

### design/sfd_store.sv
// sfd_store: two-bank frame byte memory, one write and one registered read port
// depends on sfd_pkg

module sfd_store #(
  parameter int STORE_DEPTH = sfd_pkg::STORE_DEPTH_DEFAULT,
  parameter int IW = $clog2(STORE_DEPTH)
) (
  input  logic             clk_i,
  input  sfd_pkg::sfd_wr_t wr_i,
  input  logic [IW-1:0]    wr_idx_i,
  input  sfd_pkg::sfd_rd_t rd_i,
  input  logic [IW-1:0]    rd_idx_i,
  output logic [7:0]       rd_data_o
);
  import sfd_pkg::*;

  logic [7:0] mem_q [2][STORE_DEPTH];
  logic [7:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.bank][wr_idx_i] <= wr_i.data;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.bank][rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/sfd_queue.sv
// sfd_queue: two-entry descriptor queue between front and back
// depends on sfd_pkg

module sfd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sfd_pkg::sfd_desc_t desc_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output sfd_pkg::sfd_desc_t head_o
);
  import sfd_pkg::*;

  sfd_desc_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

### design/sfd_front.sv
// sfd_front: accepts received bytes, tracks the fill count, stores frame bytes
// and hands completed frames to the queue; depends on sfd_pkg and sfd_if

module sfd_front #(
  parameter int STORE_DEPTH = sfd_pkg::STORE_DEPTH_DEFAULT,
  parameter int IW = $clog2(STORE_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfd_byte_if.sink              rx,
  output logic                  push_o,
  output sfd_pkg::sfd_desc_t    desc_o,
  input  logic                  q_full_i,
  output sfd_pkg::sfd_wr_t      wr_o,
  output logic [IW-1:0]         wr_idx_o,
  input  sfd_pkg::sfd_release_t rel_i
);
  import sfd_pkg::*;

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

  logic [CW-1:0] count_q, count_d;
  logic          bank_q, bank_d;
  logic [1:0]    busy_q, busy_d;
  logic [7:0]    last_q, last_d;
  logic [7:0]    addr1_q, addr1_d;
  logic [7:0]    addr2_q, addr2_d;
  logic [7:0]    len_q, len_d;
  logic [7:0]    type_q, type_d;

  logic            accept;
  logic            is_restart;
  logic            is_done;
  logic            is_full;
  logic [CMPW-1:0] count_ext;
  logic [CMPW-1:0] pdiff;
  logic [PLEN_W-1:0] plen;

  assign rx.ready = !busy_q[bank_q] && !q_full_i;
  assign accept   = rx.valid && rx.ready;

  // classify the incoming byte
  assign count_ext  = CMPW'(count_q);
  assign is_restart = (rx.rx_byte == MARK_HEAD) && (count_q != '0) && (last_q == MARK_HEAD);
  assign is_done    = (count_q > CW'(LEN_POS)) && (rx.rx_byte == MARK_TAIL)
                      && (CMPW'(len_q) == count_ext + CMPW'(1));
  assign is_full    = (count_ext >= CMPW'(STORE_DEPTH));

  // payload length, saturated
  always_comb begin
    pdiff = '0;
    if (count_ext > CMPW'(PAYLOAD_POS)) begin
      pdiff = count_ext - CMPW'(PAYLOAD_POS);
    end
    if (pdiff > CMPW'(MAX_RESULTS)) begin
      plen = PLEN_W'(MAX_RESULTS);
    end else begin
      plen = pdiff[PLEN_W-1:0];
    end
  end

  assign desc_o.bank        = bank_q;
  assign desc_o.addr_first  = addr1_q;
  assign desc_o.addr_second = addr2_q;
  assign desc_o.frame_type  = type_q;
  assign desc_o.plen        = plen;

  // next state of the assembler
  always_comb begin
    count_d  = count_q;
    bank_d   = bank_q;
    busy_d   = busy_q;
    last_d   = last_q;
    addr1_d  = addr1_q;
    addr2_d  = addr2_q;
    len_d    = len_q;
    type_d   = type_q;
    push_o   = 1'b0;
    wr_o.en  = 1'b0;
    wr_o.bank = bank_q;
    wr_o.data = rx.rx_byte;
    wr_idx_o = count_q[IW-1:0];

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (accept) begin
      if (is_restart) begin
        count_d = CW'(2);
        last_d  = MARK_HEAD;
      end else if (is_done) begin
        push_o         = 1'b1;
        busy_d[bank_q] = 1'b1;
        bank_d         = ~bank_q;
        count_d        = '0;
      end else if (is_full) begin
        count_d = '0;
      end else begin
        wr_o.en = 1'b1;
        count_d = count_q + CW'(1);
        last_d  = rx.rx_byte;
        if (count_q == CW'(ADDR1_POS)) begin
          addr1_d = rx.rx_byte;
        end
        if (count_q == CW'(ADDR2_POS)) begin
          addr2_d = rx.rx_byte;
        end
        if (count_q == CW'(LEN_POS)) begin
          len_d = rx.rx_byte;
        end
        if (count_q == CW'(TYPE_POS)) begin
          type_d = rx.rx_byte;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bank_q  <= 1'b0;
      busy_q  <= 2'b00;
    end else begin
      count_q <= count_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

  // mirrors of the header bytes and the last stored byte
  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    addr1_q <= addr1_d;
    addr2_q <= addr2_d;
    len_q   <= len_d;
    type_q  <= type_d;
  end

endmodule

### design/sfd_back.sv
// sfd_back: walks one completed frame at a time, reads its payload from the
// store and presents one result per byte; depends on sfd_pkg and sfd_if

module sfd_back #(
  parameter int STORE_DEPTH = sfd_pkg::STORE_DEPTH_DEFAULT,
  parameter int IW = $clog2(STORE_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  sfd_pkg::sfd_desc_t    q_head_i,
  output logic                  pop_o,
  output sfd_pkg::sfd_rd_t      rd_o,
  output logic [IW-1:0]         rd_idx_o,
  input  logic [7:0]            rd_data_i,
  output sfd_pkg::sfd_release_t rel_o,
  sfd_result_if.source          res
);
  import sfd_pkg::*;

  sfd_back_state_e   state_q, state_d;
  sfd_desc_t         desc_q, desc_d;
  logic [PLEN_W-1:0] k_q, k_d;
  logic              has_payload;
  logic              last_res;

  assign has_payload = (desc_q.plen != '0);
  assign last_res    = !has_payload || ((k_q + PLEN_W'(1)) == desc_q.plen);

  // result fields come from the held descriptor and the store read register
  assign res.address_first   = desc_q.addr_first;
  assign res.address_second  = desc_q.addr_second;
  assign res.frame_type      = desc_q.frame_type;
  assign res.payload_length  = desc_q.plen;
  assign res.payload_present = has_payload;
  assign res.payload_value   = has_payload ? rd_data_i : 8'h00;
  assign res.final_of_frame  = last_res;

  assign rd_idx_o = IW'(PAYLOAD_POS) + IW'(k_q);

  // sequencer
  always_comb begin
    state_d    = state_q;
    desc_d     = desc_q;
    k_d        = k_q;
    pop_o      = 1'b0;
    rd_o.en    = 1'b0;
    rd_o.bank  = desc_q.bank;
    rel_o.valid = 1'b0;
    rel_o.bank  = desc_q.bank;
    res.valid  = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o  = 1'b1;
          desc_d = q_head_i;
          k_d    = '0;
          state_d = (q_head_i.plen != '0) ? BK_FETCH : BK_SHOW;
        end
      end
      BK_FETCH: begin
        rd_o.en = 1'b1;
        state_d = BK_SHOW;
      end
      BK_SHOW: begin
        res.valid = 1'b1;
        if (res.ready) begin
          if (last_res) begin
            rel_o.valid = 1'b1;
            state_d     = BK_IDLE;
          end else begin
            k_d     = k_q + PLEN_W'(1);
            state_d = BK_FETCH;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // frame context
  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    k_q    <= k_d;
  end

endmodule

### tb/tb_serial_frame_deframer_core.sv
// tb_serial_frame_deframer_core: self-checking bench for the serial frame deframer
// depends on sfd_pkg, sfd_if and serial_frame_deframer_core
`timescale 1ns / 100ps

module tb_serial_frame_deframer_core;
  import sfd_pkg::*;

  localparam int STORE_DEPTH = STORE_DEPTH_DEFAULT;
  localparam int PROBE_ROWS = 25;
  localparam int RANDOM_ITEMS = 85;
  localparam int OVERSIZE_SEQ = 1;
  localparam int OVERFLOW_SEQ = 4;
  localparam int HOLD_CYCLES = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT = 4000;

  // one expected result; frame_type is a don't-care when the type byte was never stored
  typedef struct packed {
    logic [7:0]        addr_first;
    logic [7:0]        addr_second;
    logic [7:0]        frame_type;
    logic              type_known;
    logic [PLEN_W-1:0] plen;
    logic              has_payload;
    logic [7:0]        payload;
    logic              last_of_frame;
  } frame_piece_t;

  // directed row: byte to send, and a hand-written result when typed is set
  typedef struct packed {
    logic [7:0]   rx;
    logic         typed;
    frame_piece_t piece;
  } probe_row_t;

  typedef enum {
    BURST_FRAME,
    BURST_SHORT,
    BURST_BAD_LEN,
    BURST_NOISE,
    BURST_TRUNC,
    BURST_OVERSIZE,
    BURST_OVERFLOW
  } burst_kind_e;

  localparam frame_piece_t NO_PIECE = '0;

  logic clk_i = 1'b0;
  logic rst_ni;

  sfd_byte_if   rx_bus ();
  sfd_result_if res_bus ();

  serial_frame_deframer_core #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_bus),
    .res_o (res_bus)
  );

  // shadow of the frame store and its fill count
  logic [7:0]   byte_store [STORE_DEPTH];
  int           store_fill;
  frame_piece_t frame_out [MAX_RESULTS];
  frame_piece_t pending_pieces [$];
  int           mismatches = 0;
  int           quiet_cycles = 0;
  bit           tx_steady;

  // header-only frame with extreme address bytes, frame with one payload byte,
  // then a restart after a stray byte followed by a frame without a type byte
  probe_row_t probe_rows [PROBE_ROWS] = '{
    '{8'hEF, 1'b0, NO_PIECE}, '{8'hEF, 1'b0, NO_PIECE}, '{8'h00, 1'b0, NO_PIECE},
    '{8'hFF, 1'b0, NO_PIECE}, '{8'h5A, 1'b0, NO_PIECE}, '{8'h08, 1'b0, NO_PIECE},
    '{8'hC3, 1'b0, NO_PIECE},
    '{8'hFF, 1'b1, '{8'h00, 8'hFF, 8'hC3, 1'b1, 6'd0, 1'b0, 8'h00, 1'b1}},
    '{8'hEF, 1'b0, NO_PIECE}, '{8'hEF, 1'b0, NO_PIECE}, '{8'h12, 1'b0, NO_PIECE},
    '{8'h34, 1'b0, NO_PIECE}, '{8'h00, 1'b0, NO_PIECE}, '{8'h09, 1'b0, NO_PIECE},
    '{8'h7E, 1'b0, NO_PIECE}, '{8'hFF, 1'b0, NO_PIECE},
    '{8'hFF, 1'b1, '{8'h12, 8'h34, 8'h7E, 1'b1, 6'd1, 1'b1, 8'hFF, 1'b1}},
    '{8'h00, 1'b0, NO_PIECE}, '{8'hEF, 1'b0, NO_PIECE}, '{8'hEF, 1'b0, NO_PIECE},
    '{8'h56, 1'b0, NO_PIECE}, '{8'h78, 1'b0, NO_PIECE}, '{8'h11, 1'b0, NO_PIECE},
    '{8'h07, 1'b0, NO_PIECE},
    '{8'hFF, 1'b1, '{8'h56, 8'h78, 8'h00, 1'b0, 6'd0, 1'b0, 8'h00, 1'b1}}
  };

  always #1 clk_i = ~clk_i;

  // advance the shadow store by one byte, fill frame_out, return the result count
  function automatic int deframe_byte(input logic [7:0] rx);
    int plen;
    int count;
    if (rx == MARK_HEAD && store_fill > 0 && byte_store[store_fill - 1] == MARK_HEAD) begin
      byte_store[0] = MARK_HEAD;
      byte_store[1] = MARK_HEAD;
      store_fill = 2;
      return 0;
    end
    if (store_fill > LEN_POS && rx == MARK_TAIL &&
        int'(byte_store[LEN_POS]) == store_fill + 1) begin
      plen = (store_fill > PAYLOAD_POS) ? store_fill - PAYLOAD_POS : 0;
      if (plen > MAX_RESULTS) plen = MAX_RESULTS;
      count = (plen == 0) ? 1 : plen;
      for (int k = 0; k < count; k++) begin
        frame_out[k].addr_first = byte_store[ADDR1_POS];
        frame_out[k].addr_second = byte_store[ADDR2_POS];
        frame_out[k].frame_type = byte_store[TYPE_POS];
        frame_out[k].type_known = store_fill > TYPE_POS;
        frame_out[k].plen = PLEN_W'(plen);
        frame_out[k].has_payload = plen != 0;
        frame_out[k].payload = (plen != 0) ? byte_store[PAYLOAD_POS + k] : 8'h00;
        frame_out[k].last_of_frame = k + 1 >= plen;
      end
      store_fill = 0;
      return count;
    end
    // store full: byte dropped, count cleared
    if (store_fill >= STORE_DEPTH) begin
      store_fill = 0;
      return 0;
    end
    byte_store[store_fill] = rx;
    store_fill++;
    return 0;
  endfunction

  function automatic logic [7:0] pick_byte(input bit clean);
    logic [7:0] v;
    v = 8'($urandom);
    if (clean && v == MARK_HEAD) v = 8'h00;
    return v;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // offer one byte, wait for the request to be taken, then record what it causes
  task automatic push_byte(input logic [7:0] rx, input logic typed, input frame_piece_t piece);
    int gap;
    int n;
    if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_bus.valid <= 1'b1;
    rx_bus.rx_byte <= rx;
    do @(posedge clk_i); while (!rx_bus.ready);
    n = deframe_byte(rx);
    if (typed) begin
      pending_pieces.push_back(piece);
    end else begin
      for (int k = 0; k < n; k++) pending_pieces.push_back(frame_out[k]);
    end
  endtask

  // result side: random stalls, and one long hold while the oversized frame drains
  initial begin : drain_results
    int stall;
    bit steady;
    bit held_off;
    steady = 1'b0;
    held_off = 1'b0;
    res_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!res_bus.valid);
      if (!held_off && res_bus.payload_length == PLEN_W'(MAX_RESULTS)) begin
        held_off = 1'b1;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    frame_piece_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_pieces.size() == 0) begin
        $error("unexpected result: address_first %0h address_second %0h payload_value %0h",
               res_bus.address_first, res_bus.address_second, res_bus.payload_value);
        mismatches++;
      end else begin
        want = pending_pieces.pop_front();
        check_field("address_first", want.addr_first, res_bus.address_first);
        check_field("address_second", want.addr_second, res_bus.address_second);
        if (want.type_known) check_field("frame_type", want.frame_type, res_bus.frame_type);
        check_field("payload_length", 8'(want.plen), 8'(res_bus.payload_length));
        check_field("payload_present", 8'(want.has_payload), 8'(res_bus.payload_present));
        check_field("payload_value", want.payload, res_bus.payload_value);
        check_field("final_of_frame", 8'(want.last_of_frame), 8'(res_bus.final_of_frame));
      end
    end
  end

  // cycles with no request taken on either side
  always @(posedge clk_i) begin
    if ((rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("serial_frame_deframer_core verification failed");
    $finish;
  end

  initial begin : stimulus
    burst_kind_e kind;
    logic [7:0]  burst_q [$];
    int          body;
    int          ordinary;
    int          seq_no;
    int          pick;
    bit          clean;
    store_fill = 0;
    tx_steady = 1'b0;
    rst_ni <= 1'b0;
    rx_bus.valid <= 1'b0;
    rx_bus.rx_byte <= 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    foreach (probe_rows[i]) push_byte(probe_rows[i].rx, probe_rows[i].typed, probe_rows[i].piece);

    // random bursts: mostly well-formed frames, plus one oversized and one overflowing frame
    seq_no = 0;
    ordinary = 0;
    while (ordinary < RANDOM_ITEMS || seq_no <= OVERFLOW_SEQ) begin
      pick = $urandom_range(0, 19);
      if (seq_no == OVERSIZE_SEQ) kind = BURST_OVERSIZE;
      else if (seq_no == OVERFLOW_SEQ) kind = BURST_OVERFLOW;
      // a complete frame while the oversized one is held back fills both banks
      else if (seq_no == OVERSIZE_SEQ + 1) kind = BURST_FRAME;
      else if (pick < 14) kind = BURST_FRAME;
      else if (pick == 14) kind = BURST_SHORT;
      else if (pick == 15) kind = BURST_BAD_LEN;
      else if (pick < 18) kind = BURST_NOISE;
      else kind = BURST_TRUNC;
      // long frames keep 0xef out so that no restart shifts them
      clean = kind == BURST_OVERSIZE || kind == BURST_OVERFLOW;
      burst_q.delete();
      if (kind == BURST_NOISE) begin
        repeat ($urandom_range(1, 6)) burst_q.push_back(8'($urandom));
      end else begin
        burst_q.push_back(MARK_HEAD);
        burst_q.push_back(MARK_HEAD);
        repeat (3) burst_q.push_back(pick_byte(clean));
        case (kind)
          BURST_SHORT: begin
            // terminator at count 6, no type byte
            burst_q.push_back(8'(TYPE_POS + 1));
            burst_q.push_back(MARK_TAIL);
          end
          BURST_TRUNC: ;
          default: begin
            if (clean) body = STORE_DEPTH - PAYLOAD_POS;
            else if ($urandom_range(0, 7) == 0) body = $urandom_range(10, 40);
            else body = $urandom_range(0, 9);
            // length byte is the terminator position plus one
            if (kind == BURST_OVERFLOW) burst_q.push_back(8'h00);
            else if (kind == BURST_BAD_LEN)
              burst_q.push_back(8'(PAYLOAD_POS + body + 1 + $urandom_range(1, 3)));
            else burst_q.push_back(8'(PAYLOAD_POS + body + 1));
            burst_q.push_back(pick_byte(clean));
            repeat (body) burst_q.push_back(pick_byte(clean));
            // overflow: one more byte lands on a full store
            burst_q.push_back(kind == BURST_OVERFLOW ? pick_byte(1'b1) : MARK_TAIL);
          end
        endcase
      end
      foreach (burst_q[i]) push_byte(burst_q[i], 1'b0, NO_PIECE);
      ordinary += burst_q.size();
      seq_no++;
    end
    rx_bus.valid <= 1'b0;

    // let outstanding results drain, then watch for strays
    while (pending_pieces.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("serial_frame_deframer_core verification clean");
    end else begin
      $display("serial_frame_deframer_core verification failed");
    end
    $finish;
  end

endmodule
